// ===== design/sgs_pkg.sv =====
`timescale 1ns / 1ps
package sgs_pkg;

  localparam int ROWS_MAX_DEF       = 16;
  localparam int COLS_MAX_DEF       = 16;
  localparam int RATE_FRAC_BITS_DEF = 12;

  localparam int CNT_W       = 16;
  localparam int SUM_W       = 19;
  localparam int CELL_W      = 64;
  localparam int TOT_W       = 32;
  localparam int PERCENT_DIV = 100;
  localparam int PERCENT_SH  = 2;
  localparam int PERCENT_ODD = PERCENT_DIV >> PERCENT_SH;
  localparam int S_DATA_W    = 72;
  localparam int M_DATA_W    = 160;
  localparam int KIND_W      = 2;

  localparam logic [KIND_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] CMD_READ  = 2'd1;
  localparam logic [KIND_W-1:0] CMD_STEP  = 2'd2;

  localparam logic [2:0] REG_ROW_COUNT = 3'd0;
  localparam logic [2:0] REG_COL_COUNT = 3'd1;
  localparam logic [2:0] REG_INF_RATE  = 3'd2;
  localparam logic [2:0] REG_PROG_RATE = 3'd3;
  localparam logic [2:0] REG_REC_RATE  = 3'd4;

  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic wr_cell;
    logic cap_read;
    logic step_init;
    logic nb_step;
    logic mul1;
    logic mul2;
    logic div_load;
    logic div_step;
    logic upd;
    logic flip;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic              clr_last;
    logic [KIND_W-1:0] cmd;
    logic              nb_done;
    logic              cell_used;
    logic              cell_last;
    logic              out_free;
  } dp_stat_t;

endpackage

// ===== design/seir_grid_step.sv =====
`timescale 1ns / 1ps
// SEIR grid automaton. Two banks of ROWS_MAX*COLS_MAX cells of four 16-bit counts
// (S, E, I, R); a write item loads a cell, a read item returns one, a step item
// computes the next generation into the other bank and swaps. After reset a
// clearing pass over every cell zeroes both banks before the first item is
// taken. A step walks every cell through one bank read port, nine reads per
// cell, then two multiply stages and a reciprocal divide by 100; a cell outside
// the rows and columns in use skips the multiply and divide stages.
module seir_grid_step #(
  parameter int ROWS_MAX       = sgs_pkg::ROWS_MAX_DEF,
  parameter int COLS_MAX       = sgs_pkg::COLS_MAX_DEF,
  parameter int RATE_FRAC_BITS = sgs_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // row, col, susceptible_in, exposed_in, infected_in, recovered_in
  input  logic [sgs_pkg::S_DATA_W-1:0] s_tdata,
  // command
  input  logic [sgs_pkg::KIND_W-1:0]   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // susceptible_out, exposed_out, infected_out, recovered_out,
  // new_exposed_total, new_infected_total, new_recovered_total
  output logic [sgs_pkg::M_DATA_W-1:0] m_tdata,
  // kind
  output logic [sgs_pkg::KIND_W-1:0]   m_tuser,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import sgs_pkg::*;

  logic [4:0]       row_count, col_count;
  logic [CNT_W-1:0] infection_rate, progression_rate, recovery_rate;
  logic [2:0]       reg_idx;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count        <= 5'd16;
      col_count        <= 5'd16;
      infection_rate   <= '0;
      progression_rate <= '0;
      recovery_rate    <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_ROW_COUNT: row_count        <= pwdata[4:0];
        REG_COL_COUNT: col_count        <= pwdata[4:0];
        REG_INF_RATE:  infection_rate   <= pwdata[CNT_W-1:0];
        REG_PROG_RATE: progression_rate <= pwdata[CNT_W-1:0];
        REG_REC_RATE:  recovery_rate    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROW_COUNT: prdata = 32'(row_count);
      REG_COL_COUNT: prdata = 32'(col_count);
      REG_INF_RATE:  prdata = 32'(infection_rate);
      REG_PROG_RATE: prdata = 32'(progression_rate);
      REG_REC_RATE:  prdata = 32'(recovery_rate);
      default:       prdata = '0;
    endcase
  end

  sgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sgs_dp #(
    .ROWS_MAX       (ROWS_MAX),
    .COLS_MAX       (COLS_MAX),
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .row_count        (row_count),
    .col_count        (col_count),
    .infection_rate   (infection_rate),
    .progression_rate (progression_rate),
    .recovery_rate    (recovery_rate),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser)
  );

endmodule

// ===== design/sgs_ram.sv =====
`timescale 1ns / 1ps
module sgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sgs_ctrl.sv =====
`timescale 1ns / 1ps
module sgs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  sgs_pkg::dp_stat_t stat,
  output sgs_pkg::dp_cmd_t  cmd
);

  import sgs_pkg::*;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DECODE = 4'd2;
  localparam logic [3:0] ST_RWAIT  = 4'd3;
  localparam logic [3:0] ST_NB     = 4'd4;
  localparam logic [3:0] ST_MUL1   = 4'd5;
  localparam logic [3:0] ST_MUL2   = 4'd6;
  localparam logic [3:0] ST_DLOAD  = 4'd7;
  localparam logic [3:0] ST_DIV    = 4'd8;
  localparam logic [3:0] ST_UPD    = 4'd9;
  localparam logic [3:0] ST_RESP   = 4'd10;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.cmd)
          CMD_WRITE: begin
            cmd.wr_cell = 1'b1;
            state_next  = ST_RESP;
          end
          CMD_READ: state_next = ST_RWAIT;
          CMD_STEP: begin
            cmd.step_init = 1'b1;
            state_next    = ST_NB;
          end
          default: state_next = ST_RESP;
        endcase
      end
      ST_RWAIT: begin
        cmd.cap_read = 1'b1;
        state_next   = ST_RESP;
      end
      ST_NB: begin
        cmd.nb_step = 1'b1;
        if (stat.nb_done) state_next = stat.cell_used ? ST_MUL1 : ST_UPD;
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        if (stat.cell_last) begin
          cmd.flip   = 1'b1;
          state_next = ST_RESP;
        end else begin
          state_next = ST_NB;
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== design/sgs_dp.sv =====
`timescale 1ns / 1ps
module sgs_dp #(
  parameter int ROWS_MAX       = sgs_pkg::ROWS_MAX_DEF,
  parameter int COLS_MAX       = sgs_pkg::COLS_MAX_DEF,
  parameter int RATE_FRAC_BITS = sgs_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sgs_pkg::dp_cmd_t               cmd,
  output sgs_pkg::dp_stat_t              stat,
  input  logic [4:0]                     row_count,
  input  logic [4:0]                     col_count,
  input  logic [sgs_pkg::CNT_W-1:0]      infection_rate,
  input  logic [sgs_pkg::CNT_W-1:0]      progression_rate,
  input  logic [sgs_pkg::CNT_W-1:0]      recovery_rate,
  input  logic [sgs_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic [sgs_pkg::KIND_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sgs_pkg::M_DATA_W-1:0]   m_tdata,
  output logic [sgs_pkg::KIND_W-1:0]     m_tuser
);

  import sgs_pkg::*;

  localparam int CELLS = ROWS_MAX * COLS_MAX;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS_MAX);
  localparam int CW    = $clog2(COLS_MAX);
  localparam int RCW   = $clog2(ROWS_MAX + 1);
  localparam int CCW   = $clog2(COLS_MAX + 1);
  localparam int P2W   = 2 * CNT_W + SUM_W;
  localparam int XW    = P2W - RATE_FRAC_BITS;
  localparam int NIW   = 2 * CNT_W - RATE_FRAC_BITS;
  localparam int EW    = XW + 2;
  localparam int YW    = XW - PERCENT_SH;
  localparam int RSH   = YW + $clog2(PERCENT_ODD);
  localparam int MW    = YW + 1;
  localparam int YL    = (YW + 1) / 2;
  localparam int YH    = YW - YL;
  localparam int PW    = MW + YW;
  localparam logic [MW-1:0] RECIP_M =
    MW'(((64'd1 << RSH) + 64'(PERCENT_ODD) - 64'd1) / 64'(PERCENT_ODD));

  // item registers
  logic [KIND_W-1:0] cmd_q;
  logic [3:0]        row_q, col_q;
  logic [CELL_W-1:0] win;
  logic [CELL_W-1:0] rd_cell;
  logic              active;
  logic [AW-1:0]     clr_addr;

  // step registers
  logic [RW-1:0]     cur_r;
  logic [CW-1:0]     cur_c;
  logic [1:0]        dr_i, dc_i;
  logic [3:0]        nb_cnt;
  logic              nb_ok_d, nb_ctr_d;
  logic [SUM_W-1:0]  sum;
  logic [CELL_W-1:0] center;
  logic [2*CNT_W-1:0] p_s, p_e, p_i;
  logic [P2W-1:0]    p2;
  logic [NIW-1:0]    ni, nr;
  logic [XW-1:0]     dq;
  logic [MW+YL-1:0]  pp_lo;
  logic [MW+YH-1:0]  pp_hi;
  logic [TOT_W-1:0]  tot_e, tot_i, tot_r;

  logic [RCW-1:0]    rows_eff;
  logic [CCW-1:0]    cols_eff;
  logic              addr_ok;
  logic [AW-1:0]     item_idx, cur_idx, nb_idx, raddr;
  logic [RW+1:0]     nr_ext;
  logic [CW+1:0]     nc_ext;
  logic              valid_r, valid_c, is_center, cell_used, nb_valid;
  logic [RW-1:0]     addr_r;
  logic [CW-1:0]     addr_c;
  logic [CELL_W-1:0] rda, rdb, rd_word, new_word, wdata;
  logic              we_a, we_b;
  logic [AW-1:0]     waddr;
  logic [YW-1:0]     y_in;
  logic [PW-1:0]     pp_sum;
  logic [CNT_W-1:0]  s_old, e_old, i_old, r_old, s_new, e_new, i_new, r_new;
  logic [EW-1:0]     e_w, i_w, r_w;
  logic [XW:0]       te_sum;
  logic [TOT_W:0]    ti_sum, tr_sum;
  logic [31:0]       rc32, cc32;

  assign rc32     = 32'(row_count);
  assign cc32     = 32'(col_count);
  assign rows_eff = RCW'((rc32 > 32'(ROWS_MAX)) ? 32'(ROWS_MAX) : rc32);
  assign cols_eff = CCW'((cc32 > 32'(COLS_MAX)) ? 32'(COLS_MAX) : cc32);

  assign addr_ok  = (32'(row_q) < 32'(ROWS_MAX)) && (32'(col_q) < 32'(COLS_MAX));
  assign item_idx = AW'(32'(row_q) * 32'(COLS_MAX) + 32'(col_q));
  assign cur_idx  = AW'(32'(cur_r) * 32'(COLS_MAX) + 32'(cur_c));

  // neighbor walk
  assign nr_ext    = (RW+2)'(cur_r) + (RW+2)'(dr_i) - (RW+2)'(1);
  assign nc_ext    = (CW+2)'(cur_c) + (CW+2)'(dc_i) - (CW+2)'(1);
  assign valid_r   = nr_ext < (RW+2)'(rows_eff);
  assign valid_c   = nc_ext < (CW+2)'(cols_eff);
  assign is_center = (dr_i == 2'd1) && (dc_i == 2'd1);
  assign cell_used = ((RCW+1)'(cur_r) < (RCW+1)'(rows_eff))
                  && ((CCW+1)'(cur_c) < (CCW+1)'(cols_eff));
  assign nb_valid  = valid_r && valid_c && cell_used && !is_center;
  assign addr_r    = valid_r ? nr_ext[RW-1:0] : cur_r;
  assign addr_c    = valid_c ? nc_ext[CW-1:0] : cur_c;
  assign nb_idx    = AW'(32'(addr_r) * 32'(COLS_MAX) + 32'(addr_c));
  assign raddr     = cmd.nb_step ? nb_idx : item_idx;

  sgs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_bank_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rda)
  );
  sgs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_bank_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdb)
  );

  assign rd_word = active ? rdb : rda;

  // new generation of the current cell
  assign s_old = center[15:0];
  assign e_old = center[31:16];
  assign i_old = center[47:32];
  assign r_old = center[63:48];

  assign s_new = (XW'(s_old) < dq) ? '0 : s_old - dq[CNT_W-1:0];
  assign e_w   = EW'(e_old) + EW'(dq) - EW'(ni);
  assign i_w   = EW'(i_old) + EW'(ni) - EW'(nr);
  assign r_w   = EW'(r_old) + EW'(nr);
  assign e_new = e_w[EW-1] ? '0 : ((|e_w[EW-2:CNT_W]) ? '1 : e_w[CNT_W-1:0]);
  assign i_new = i_w[EW-1] ? '0 : ((|i_w[EW-2:CNT_W]) ? '1 : i_w[CNT_W-1:0]);
  assign r_new = (|r_w[EW-1:CNT_W]) ? '1 : r_w[CNT_W-1:0];
  assign new_word = cell_used ? {r_new, i_new, e_new, s_new} : center;

  assign te_sum = (XW+1)'(tot_e) + (XW+1)'(dq);
  assign ti_sum = (TOT_W+1)'(tot_i) + (TOT_W+1)'(ni);
  assign tr_sum = (TOT_W+1)'(tot_r) + (TOT_W+1)'(nr);

  // bank writes
  assign we_a  = cmd.clr_wr || (cmd.wr_cell && addr_ok && !active) || (cmd.upd && active);
  assign we_b  = cmd.clr_wr || (cmd.wr_cell && addr_ok && active) || (cmd.upd && !active);
  assign waddr = cmd.clr_wr ? clr_addr : (cmd.upd ? cur_idx : item_idx);
  assign wdata = cmd.clr_wr ? '0 : (cmd.upd ? new_word : win);

  // divide by the percent constant: drop the rate fraction bits and the power of two,
  // then multiply by the reciprocal of the odd part in two partial products and shift
  assign y_in   = p2[P2W-1:RATE_FRAC_BITS+PERCENT_SH];
  assign pp_sum = PW'(pp_lo) + (PW'(pp_hi) << YL);

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_addr <= clr_addr + AW'(1);
      if (cmd.flip) active <= ~active;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q <= s_tuser;
      row_q <= s_tdata[3:0];
      col_q <= s_tdata[7:4];
      win   <= s_tdata[71:8];
    end
    if (cmd.cap_read) rd_cell <= addr_ok ? rd_word : '0;

    if (cmd.step_init) begin
      cur_r <= '0;
      cur_c <= '0;
      tot_e <= '0;
      tot_i <= '0;
      tot_r <= '0;
    end
    if (cmd.step_init || cmd.upd) begin
      nb_cnt  <= '0;
      dr_i    <= '0;
      dc_i    <= '0;
      sum     <= '0;
      nb_ok_d <= 1'b0;
      nb_ctr_d <= 1'b0;
    end

    if (cmd.nb_step) begin
      nb_cnt   <= nb_cnt + 4'd1;
      nb_ok_d  <= nb_valid;
      nb_ctr_d <= is_center;
      if (dc_i == 2'd2) begin
        dc_i <= '0;
        dr_i <= dr_i + 2'd1;
      end else begin
        dc_i <= dc_i + 2'd1;
      end
      if (nb_ok_d) sum <= sum + SUM_W'(rd_word[47:32]);
      if (nb_ctr_d) center <= rd_word;
    end

    if (cmd.mul1) begin
      p_s <= infection_rate * s_old;
      p_e <= progression_rate * e_old;
      p_i <= recovery_rate * i_old;
    end
    if (cmd.mul2) begin
      p2 <= P2W'(p_s) * P2W'(sum);
      ni <= p_e[2*CNT_W-1:RATE_FRAC_BITS];
      nr <= p_i[2*CNT_W-1:RATE_FRAC_BITS];
    end
    if (cmd.div_load) begin
      pp_lo <= (MW+YL)'(RECIP_M) * (MW+YL)'(y_in[YL-1:0]);
      pp_hi <= (MW+YH)'(RECIP_M) * (MW+YH)'(y_in[YW-1:YL]);
    end
    if (cmd.div_step) begin
      dq <= XW'(pp_sum >> RSH);
    end

    if (cmd.upd) begin
      if (cell_used) begin
        tot_e <= (|te_sum[XW:TOT_W]) ? '1 : te_sum[TOT_W-1:0];
        tot_i <= ti_sum[TOT_W] ? '1 : ti_sum[TOT_W-1:0];
        tot_r <= tr_sum[TOT_W] ? '1 : tr_sum[TOT_W-1:0];
      end
      if (cur_c == CW'(COLS_MAX - 1)) begin
        cur_c <= '0;
        cur_r <= cur_r + RW'(1);
      end else begin
        cur_c <= cur_c + CW'(1);
      end
    end

    if (cmd.load_out) begin
      m_tuser <= cmd_q;
      m_tdata <= {(cmd_q == CMD_STEP) ? {tot_r, tot_i, tot_e} : {3*TOT_W{1'b0}},
                  (cmd_q == CMD_READ) ? rd_cell : {CELL_W{1'b0}}};
    end
  end

  assign stat.clr_last  = (clr_addr == AW'(CELLS - 1));
  assign stat.cmd       = cmd_q;
  assign stat.nb_done   = (nb_cnt == 4'd9);
  assign stat.cell_used = cell_used;
  assign stat.cell_last = (cur_r == RW'(ROWS_MAX - 1)) && (cur_c == CW'(COLS_MAX - 1));
  assign stat.out_free  = !m_tvalid || m_tready;

endmodule

// ===== tb/sv/seir_grid_step_tb.sv =====
`timescale 1ns / 1ps
module seir_grid_step_tb;
  import sgs_pkg::*;

  localparam logic [KIND_W-1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [KIND_W-1:0] cmd;
    logic [3:0]        row;
    logic [3:0]        col;
    logic [15:0]       s;
    logic [15:0]       e;
    logic [15:0]       i;
    logic [15:0]       r;
  } cell_op_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [15:0]       s;
    logic [15:0]       e;
    logic [15:0]       i;
    logic [15:0]       r;
    logic [31:0]       new_e;
    logic [31:0]       new_i;
    logic [31:0]       new_r;
  } cell_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0] m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  seir_grid_step dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // grid mirror and register copies
  logic [63:0] grid [2][256];
  bit          act_bank;
  int unsigned rows_cfg, cols_cfg;
  longint      beta, sigma, gamma;

  cell_op_t  pending_ops[$];
  cell_res_t expected_res[$];
  cell_op_t  cur_op;
  bit        tx_busy;
  bit        tx_idle_on = 1'b1;
  bit        rx_idle_on = 1'b1;
  bit        long_hold_req;
  int        tx_gap, rx_gap, rx_hold;
  int        errors;
  int        cycles;

  function automatic longint clamp16(longint v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  function automatic longint sat32(longint v);
    return (v > 64'hFFFFFFFF) ? 64'hFFFFFFFF : v;
  endfunction

  function automatic cell_res_t apply_cell_op(cell_op_t op);
    cell_res_t res;
    logic [63:0] cell_word;
    logic [15:0] s_nx, e_nx, i_nx, r_nx;
    int rows, cols, nr, nc;
    longint sum, s, e, i, rc, ne, ni, nrm, te, ti, tr;
    res = '0;
    res.kind = op.cmd;
    case (op.cmd)
      CMD_WRITE: grid[act_bank][{op.row, op.col}] = {op.r, op.i, op.e, op.s};
      CMD_READ: {res.r, res.i, res.e, res.s} = grid[act_bank][{op.row, op.col}];
      CMD_STEP: begin
        rows = (rows_cfg > 16) ? 16 : rows_cfg;
        cols = (cols_cfg > 16) ? 16 : cols_cfg;
        te = 0;
        ti = 0;
        tr = 0;
        for (int r = 0; r < 16; r++) begin
          for (int c = 0; c < 16; c++) begin
            cell_word = grid[act_bank][r*16+c];
            if (r >= rows || c >= cols) begin
              grid[!act_bank][r*16+c] = cell_word;
              continue;
            end
            sum = 0;
            for (int dr = -1; dr <= 1; dr++) begin
              for (int dc = -1; dc <= 1; dc++) begin
                nr = r + dr;
                nc = c + dc;
                if ((dr == 0 && dc == 0) || nr < 0 || nc < 0 || nr >= rows || nc >= cols)
                  continue;
                sum += longint'(grid[act_bank][nr*16+nc][47:32]);
              end
            end
            s = longint'(cell_word[15:0]);
            e = longint'(cell_word[31:16]);
            i = longint'(cell_word[47:32]);
            rc = longint'(cell_word[63:48]);
            ne = (beta * s * sum) / (100 << RATE_FRAC_BITS_DEF);
            ni = (sigma * e) >> RATE_FRAC_BITS_DEF;
            nrm = (gamma * i) >> RATE_FRAC_BITS_DEF;
            te = sat32(te + ne);
            ti = sat32(ti + ni);
            tr = sat32(tr + nrm);
            s_nx = 16'(clamp16(s - ne));
            e_nx = 16'(clamp16(e + ne - ni));
            i_nx = 16'(clamp16(i + ni - nrm));
            r_nx = 16'(clamp16(rc + nrm));
            grid[!act_bank][r*16+c] = {r_nx, i_nx, e_nx, s_nx};
          end
        end
        act_bank = !act_bank;
        res.new_e = te[31:0];
        res.new_i = ti[31:0];
        res.new_r = tr[31:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string fld, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", fld, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_busy = 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_res.push_back(apply_cell_op(cur_op));
        tx_busy = 1'b0;
      end
      if (!tx_busy && tx_gap == 0 && tx_idle_on && $urandom_range(0, 9) == 0)
        tx_gap = $urandom_range(1, 15);
      if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (!tx_busy && pending_ops.size() > 0) begin
        cur_op = pending_ops.pop_front();
        tx_busy = 1'b1;
        s_tvalid <= 1'b1;
        s_tdata <= {cur_op.r, cur_op.i, cur_op.e, cur_op.s, cur_op.col, cur_op.row};
        s_tuser <= cur_op.cmd;
      end else if (!tx_busy) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cell_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap = 0;
      rx_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected item kind", m_tuser, 0);
        end else begin
          want = expected_res.pop_front();
          if (m_tuser !== want.kind) report_mismatch("kind", m_tuser, want.kind);
          if (m_tdata[15:0] !== want.s) report_mismatch("susceptible", m_tdata[15:0], want.s);
          if (m_tdata[31:16] !== want.e) report_mismatch("exposed", m_tdata[31:16], want.e);
          if (m_tdata[47:32] !== want.i) report_mismatch("infected", m_tdata[47:32], want.i);
          if (m_tdata[63:48] !== want.r) report_mismatch("recovered", m_tdata[63:48], want.r);
          if (m_tdata[95:64] !== want.new_e)
            report_mismatch("new_exposed", m_tdata[95:64], want.new_e);
          if (m_tdata[127:96] !== want.new_i)
            report_mismatch("new_infected", m_tdata[127:96], want.new_i);
          if (m_tdata[159:128] !== want.new_r)
            report_mismatch("new_recovered", m_tdata[159:128], want.new_r);
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_hold = 2000;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(1, 15);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ROW_COUNT: rows_cfg = val[4:0];
      REG_COL_COUNT: cols_cfg = val[4:0];
      REG_INF_RATE:  beta = val[15:0];
      REG_PROG_RATE: sigma = val[15:0];
      default:       gamma = val[15:0];
    endcase
  endtask

  task automatic set_grid(int unsigned rows, int unsigned cols, int unsigned b,
                          int unsigned sg, int unsigned gm);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
    write_reg(REG_INF_RATE, b);
    write_reg(REG_PROG_RATE, sg);
    write_reg(REG_REC_RATE, gm);
  endtask

  task automatic add_op(logic [KIND_W-1:0] cmd, int row, int col,
                        int s, int e, int i, int r);
    cell_op_t op;
    op.cmd = cmd;
    op.row = 4'(row);
    op.col = 4'(col);
    op.s = 16'(s);
    op.e = 16'(e);
    op.i = 16'(i);
    op.r = 16'(r);
    pending_ops.push_back(op);
  endtask

  function automatic logic [15:0] rand_count();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 255));
      2: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic add_random_ops(int n, int rows, int cols);
    cell_op_t op;
    int pick;
    for (int k = 0; k < n; k++) begin
      op = '0;
      op.row = 4'($urandom_range(0, 15));
      op.col = 4'($urandom_range(0, 15));
      op.s = rand_count();
      op.e = rand_count();
      op.i = rand_count();
      op.r = rand_count();
      if (rows > 0 && cols > 0 && $urandom_range(0, 3) != 0) begin
        op.row = 4'($urandom_range(0, rows - 1));
        op.col = 4'($urandom_range(0, cols - 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) op.cmd = CMD_WRITE;
      else if (pick < 80) op.cmd = CMD_READ;
      else if (pick < 93) op.cmd = CMD_STEP;
      else op.cmd = CMD_NONE;
      pending_ops.push_back(op);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ops.size() > 0 || tx_busy || expected_res.size() > 0);
    repeat (30) @(negedge clk);
  endtask

  initial begin
    int rows, cols, rsel;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    rows_cfg = 16;
    cols_cfg = 16;

    // extremes, every command, full grid step at maximum rates
    set_grid(16, 16, 65535, 65535, 65535);
    add_op(CMD_WRITE, 0, 0, 65535, 65535, 65535, 65535);
    add_op(CMD_WRITE, 15, 15, 1000, 500, 65535, 65534);
    add_op(CMD_WRITE, 0, 1, 65535, 0, 3, 0);
    add_op(CMD_WRITE, 1, 0, 40000, 20, 1, 7);
    add_op(CMD_READ, 0, 0, 0, 0, 0, 0);
    add_op(CMD_READ, 15, 15, 0, 0, 0, 0);
    add_op(CMD_READ, 5, 5, 0, 0, 0, 0);
    add_op(CMD_NONE, 9, 6, 65535, 1, 65535, 1);
    add_op(CMD_STEP, 15, 15, 65535, 65535, 65535, 65535);
    add_op(CMD_READ, 0, 0, 0, 0, 0, 0);
    add_op(CMD_READ, 0, 1, 0, 0, 0, 0);
    add_op(CMD_READ, 15, 15, 0, 0, 0, 0);
    wait_drained();

    // oversized counts act as the full grid
    set_grid(31, 17, 4096, 2048, 1024);
    add_op(CMD_WRITE, 2, 2, 30000, 3000, 300, 30);
    add_op(CMD_STEP, 0, 0, 0, 0, 0, 0);
    add_op(CMD_READ, 2, 2, 0, 0, 0, 0);
    add_op(CMD_READ, 1, 0, 0, 0, 0, 0);
    wait_drained();

    // no rows in use: step copies the grid
    set_grid(0, 5, 0, 0, 0);
    add_op(CMD_WRITE, 3, 3, 100, 200, 300, 400);
    add_op(CMD_STEP, 0, 0, 0, 0, 0, 0);
    add_op(CMD_READ, 3, 3, 0, 0, 0, 0);
    add_op(CMD_READ, 0, 0, 0, 0, 0, 0);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      rsel = $urandom_range(0, 9);
      if (rsel == 0) begin
        rows = $urandom_range(17, 31);
        cols = $urandom_range(0, 31);
      end else if (rsel == 1) begin
        rows = $urandom_range(0, 1);
        cols = $urandom_range(0, 3);
      end else begin
        rows = $urandom_range(1, 6);
        cols = $urandom_range(1, 6);
      end
      if (ph >= 10) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      set_grid(rows, cols, $urandom_range(0, 65535), $urandom_range(0, 65535),
               (ph == 4) ? 0 : $urandom_range(0, 65535));
      if (ph == 2) begin
        @(negedge clk);
        long_hold_req = 1'b1;
      end
      add_random_ops(32, (rows > 16) ? 16 : rows, (cols > 16) ? 16 : cols);
      wait_drained();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== seir_grid_step.f =====
design/sgs_pkg.sv
design/sgs_ram.sv
design/sgs_ctrl.sv
design/sgs_dp.sv
design/seir_grid_step.sv
tb/sv/seir_grid_step_tb.sv
